// File: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// File: hdl/lfp_pkg.sv
`timescale 1ns / 1ps

package lfp_pkg;

  localparam int POINTS_PER_FRAME = 12;
  localparam int POINT_SIZE       = 15;
  localparam int HEADER_END_I     = 8;

  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [2:0] SYNC_COUNT   = 3'd4;
  localparam logic [7:0] ADDR_POS     = 8'd4;
  localparam logic [7:0] CMD_POS      = 8'd5;
  localparam logic [7:0] OFS_POS      = 8'd6;
  localparam logic [7:0] HEADER_END   = 8'(HEADER_END_I);
  localparam logic [7:0] CHECKSUM_POS = 8'(HEADER_END_I + POINT_SIZE * POINTS_PER_FRAME);
  localparam logic [3:0] PT_LAST      = 4'(POINT_SIZE - 1);

  typedef struct packed {
    logic               is_status;
    logic [3:0]         point_index;
    logic signed [15:0] distance;
    logic [15:0]        noise;
    logic [31:0]        peak;
    logic [7:0]         confidence;
    logic [31:0]        integration;
    logic signed [15:0] reference_tof;
    logic [7:0]         dev_addr;
    logic [7:0]         cmd_byte;
    logic [7:0]         chunk_ofs;
    logic               checksum_ok;
  } lfp_result_t;

endpackage

// File: hdl/lfp_in_if.sv
`timescale 1ns / 1ps

interface lfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/lfp_out_if.sv
`timescale 1ns / 1ps

interface lfp_out_if;
  logic               valid;
  logic               ready;
  logic               is_status;
  logic [3:0]         point_index;
  logic signed [15:0] distance;
  logic [15:0]        noise;
  logic [31:0]        peak;
  logic [7:0]         confidence;
  logic [31:0]        integration;
  logic signed [15:0] reference_tof;
  logic [7:0]         dev_addr;
  logic [7:0]         cmd_byte;
  logic [7:0]         chunk_ofs;
  logic               checksum_ok;

  modport source (
    output valid, output is_status, output point_index, output distance, output noise,
    output peak, output confidence, output integration, output reference_tof,
    output dev_addr, output cmd_byte, output chunk_ofs, output checksum_ok,
    input ready
  );
  modport sink (
    input valid, input is_status, input point_index, input distance, input noise,
    input peak, input confidence, input integration, input reference_tof,
    input dev_addr, input cmd_byte, input chunk_ofs, input checksum_ok,
    output ready
  );
endinterface

// File: hdl/lfp_parse_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfp_parse_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output lfp_pkg::lfp_result_t res
);
  import lfp_pkg::*;

  logic [2:0] sync_seen, sync_seen_next;
  logic [7:0] frame_position, frame_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [3:0] points_done, points_done_next;
  logic [3:0] pt_cnt, pt_cnt_next;
  logic [7:0] header_address, header_address_next;
  logic [7:0] header_command, header_command_next;
  logic [7:0] header_offset, header_offset_next;
  logic [7:0] pt_bytes [0:POINT_SIZE-2];

  logic in_frame;
  logic at_checksum;
  logic in_points;
  logic pt_write;

  assign in_frame    = (sync_seen == SYNC_COUNT);
  assign at_checksum = in_frame && (frame_position >= CHECKSUM_POS);
  assign in_points   = in_frame && !at_checksum && (frame_position >= HEADER_END);
  assign pt_write    = step && in_points && (pt_cnt != PT_LAST);

  always_comb begin
    sync_seen_next      = sync_seen;
    frame_position_next = frame_position;
    running_sum_next    = running_sum;
    points_done_next    = points_done;
    pt_cnt_next         = pt_cnt;
    header_address_next = header_address;
    header_command_next = header_command;
    header_offset_next  = header_offset;
    res_valid           = 1'b0;
    if (step) begin
      priority if (!in_frame) begin
        if (rx_byte == SYNC_BYTE) begin
          sync_seen_next = sync_seen + 3'd1;
          if (sync_seen_next == SYNC_COUNT) begin
            frame_position_next = 8'(SYNC_COUNT);
            running_sum_next    = 8'd0;
            points_done_next    = 4'd0;
            pt_cnt_next         = 4'd0;
          end
        end else begin
          sync_seen_next = 3'd0;
        end
      end else if (at_checksum) begin
        res_valid           = 1'b1;
        sync_seen_next      = 3'd0;
        frame_position_next = 8'd0;
        running_sum_next    = 8'd0;
        points_done_next    = 4'd0;
      end else begin
        running_sum_next    = running_sum + rx_byte;
        frame_position_next = frame_position + 8'd1;
        if (!in_points) begin
          if (frame_position == ADDR_POS) header_address_next = rx_byte;
          if (frame_position == CMD_POS) header_command_next = rx_byte;
          if (frame_position == OFS_POS) header_offset_next = rx_byte;
        end else if (pt_cnt == PT_LAST) begin
          res_valid        = 1'b1;
          pt_cnt_next      = 4'd0;
          points_done_next = points_done + 4'd1;
        end else begin
          pt_cnt_next = pt_cnt + 4'd1;
        end
      end
    end
  end

  always_comb begin
    res           = '0;
    res.dev_addr  = header_address;
    res.cmd_byte  = header_command;
    res.chunk_ofs = header_offset;
    if (at_checksum) begin
      res.is_status   = 1'b1;
      res.checksum_ok = (running_sum == rx_byte);
    end else begin
      res.point_index   = points_done;
      res.distance      = {pt_bytes[1], pt_bytes[0]};
      res.noise         = {pt_bytes[3], pt_bytes[2]};
      res.peak          = {pt_bytes[7], pt_bytes[6], pt_bytes[5], pt_bytes[4]};
      res.confidence    = pt_bytes[8];
      res.integration   = {pt_bytes[12], pt_bytes[11], pt_bytes[10], pt_bytes[9]};
      res.reference_tof = {rx_byte, pt_bytes[13]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_seen      <= 3'd0;
      frame_position <= 8'd0;
      running_sum    <= 8'd0;
      points_done    <= 4'd0;
      pt_cnt         <= 4'd0;
      header_address <= 8'd0;
      header_command <= 8'd0;
      header_offset  <= 8'd0;
    end else begin
      sync_seen      <= sync_seen_next;
      frame_position <= frame_position_next;
      running_sum    <= running_sum_next;
      points_done    <= points_done_next;
      pt_cnt         <= pt_cnt_next;
      header_address <= header_address_next;
      header_command <= header_command_next;
      header_offset  <= header_offset_next;
    end
  end

  // point byte store, each entry loaded at its own slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < POINT_SIZE - 1; i++) begin
      if (pt_write && (pt_cnt == 4'(i))) begin
        pt_bytes[i] <= rx_byte;
      end
    end
  end

  `ASSERT_CLK(a_sync_range, clk, rst, sync_seen <= SYNC_COUNT)
  `ASSERT_CLK(a_pos_range, clk, rst, frame_position <= CHECKSUM_POS)
  `ASSERT_NEVER(a_result_in_hunt, clk, rst, res_valid && !in_frame)
  `ASSERT_CLK(a_status_rearm, clk, rst, (res_valid && at_checksum) |=> !in_frame)

endmodule

// File: hdl/lfp_out_reg.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lfp_pkg::lfp_result_t res,
  output logic                 free,
  lfp_out_if.source            out_ch
);
  import lfp_pkg::*;

  logic        valid, valid_next;
  lfp_result_t data;

  assign free = !valid || out_ch.ready;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (out_ch.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.is_status     = data.is_status;
  assign out_ch.point_index   = data.point_index;
  assign out_ch.distance      = data.distance;
  assign out_ch.noise         = data.noise;
  assign out_ch.peak          = data.peak;
  assign out_ch.confidence    = data.confidence;
  assign out_ch.integration   = data.integration;
  assign out_ch.reference_tof = data.reference_tof;
  assign out_ch.dev_addr      = data.dev_addr;
  assign out_ch.cmd_byte      = data.cmd_byte;
  assign out_ch.chunk_ofs     = data.chunk_ofs;
  assign out_ch.checksum_ok   = data.checksum_ok;

  `ASSERT_NEVER(a_load_overwrite, clk, rst, load && !free)
  `ASSERT_CLK(a_hold_stalled, clk, rst, (valid && !out_ch.ready) |=> valid)
  `ASSERT_CLK(a_load_shows, clk, rst, load |=> valid)

endmodule

// File: hdl/lidar_frame_parser.sv
`timescale 1ns / 1ps
// byte-serial parser for fixed-length lidar frames
// in_ch takes one received byte per beat; the parser hunts for four 0xaa sync
// bytes, captures address, command and chunk offset, then twelve 15-byte points
// and a checksum byte
// out_ch carries one beat per completed point and one frame status beat after
// the checksum byte, with the header fields and a checksum match flag
// a completing byte passes the input byte register, then the result register
// throughput: one byte per cycle unless out_ch stalls a held beat, set by the
// single parse step between the input byte register and the result register
// reset (rst, synchronous) returns to the sync hunt with no beat pending
// a stalled out_ch holds its beat; one more byte can wait in the input
// register, after which in_ch.ready drops until the result beat is taken
module lidar_frame_parser (
  input  logic     clk,
  input  logic     rst,
  lfp_in_if.sink   in_ch,
  lfp_out_if.source out_ch
);
  import lfp_pkg::*;

  logic        byte_valid;
  logic [7:0]  byte_q;
  logic        advance;
  logic        free;
  logic        res_valid;
  lfp_result_t res;

  assign advance     = byte_valid && free;
  assign in_ch.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_q <= in_ch.rx_byte;
    end
  end

  lfp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (byte_q),
    .res_valid (res_valid),
    .res       (res)
  );

  lfp_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (res_valid),
    .res    (res),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule
